FILE: rtl/vd_pkg.sv
package vd_pkg;

	localparam int DEPTH_DEF        = 5;
	localparam int SAMPLE_WIDTH_DEF = 8;
	localparam int METRIC_WIDTH_DEF = 20;

	// sample fraction bits, ideal levels are multiples of 2**FRAC_BITS
	localparam int FRAC_BITS  = 5;
	localparam int NUM_STATES = 4;
	localparam int NUM_LEVELS = 5;

endpackage

FILE: rtl/vd_in_if.sv
interface vd_in_if #(
	parameter int SAMPLE_WIDTH = vd_pkg::SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample;
	logic                           end_of_block;

	modport source (output valid, output sample, output end_of_block, input ready);
	modport sink (input valid, input sample, input end_of_block, output ready);
endinterface

FILE: rtl/vd_out_if.sv
interface vd_out_if;
	logic valid;
	logic ready;
	logic bit_res;
	logic last_of_run;

	modport source (output valid, output bit_res, output last_of_run, input ready);
	modport sink (input valid, input bit_res, input last_of_run, output ready);
endinterface

FILE: rtl/viterbi_detector_pr121_4state.sv
// channel   direction  payload                      handshake
// samp_ch   sink       sample, end_of_block         valid/ready
// bit_ch    source     bit_res, last_of_run         valid/ready
//
// one sample per cycle while bit_ch is ready: input register, one pass of branch metrics, four acs units,
// minimum search and register exchange, then the result register
// a sample yields no bit, one bit, or on end_of_block up to DEPTH+1 bits,
// one bit per cycle from the result register while bit_ch is ready; samples stall meanwhile
// arst_n clears metrics, survivors, fill count and both stages
// the input register takes one sample while a result waits on bit_ch, then stalls
module viterbi_detector_pr121_4state #(
	parameter int DEPTH        = vd_pkg::DEPTH_DEF,
	parameter int SAMPLE_WIDTH = vd_pkg::SAMPLE_WIDTH_DEF,
	parameter int METRIC_WIDTH = vd_pkg::METRIC_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	vd_in_if.sink     samp_ch,
	vd_out_if.source  bit_ch
);
	import vd_pkg::*;

	localparam int SURV_LEN = DEPTH + 1;
	localparam int FILL_W   = $clog2(DEPTH + 1);
	localparam int CNT_W    = $clog2(DEPTH + 2);
	localparam int LVL_W    = FRAC_BITS + 3;
	localparam int DIFF_W   = ((SAMPLE_WIDTH > LVL_W) ? SAMPLE_WIDTH : LVL_W) + 1;
	localparam int SQ_W     = 2 * DIFF_W;
	localparam int SUM_W    = ((METRIC_WIDTH > SQ_W) ? METRIC_WIDTH : SQ_W) + 1;
	localparam logic [SUM_W-1:0] METRIC_MAX =
		{{(SUM_W - METRIC_WIDTH){1'b0}}, {METRIC_WIDTH{1'b1}}};

	logic signed [SAMPLE_WIDTH-1:0] sample_s1;
	logic                           eob_s1;
	logic                           valid_s1;

	logic [METRIC_WIDTH-1:0] metric_q [NUM_STATES];
	logic [SURV_LEN-1:0]     surv_q   [NUM_STATES];
	logic [FILL_W-1:0]       fill_q;

	logic [SURV_LEN-1:0] bits_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                flush_q;

	logic signed [DIFF_W-1:0] diff [NUM_LEVELS];
	logic [DIFF_W-1:0]        mag  [NUM_LEVELS];
	logic [SQ_W-1:0]          bm   [NUM_LEVELS];

	logic [SUM_W-1:0]        sum_a [NUM_STATES];
	logic [SUM_W-1:0]        sum_b [NUM_STATES];
	logic [METRIC_WIDTH-1:0] ca    [NUM_STATES];
	logic [METRIC_WIDTH-1:0] cb    [NUM_STATES];
	logic [METRIC_WIDTH-1:0] nm    [NUM_STATES];
	logic [METRIC_WIDTH-1:0] norm  [NUM_STATES];
	logic [SURV_LEN-1:0]     ns    [NUM_STATES];
	logic [1:0]              best;
	logic [METRIC_WIDTH-1:0] lo;

	logic [CNT_W-1:0]    nvalid;
	logic [FILL_W-1:0]   fill_nxt;
	logic [CNT_W-1:0]    emit_cnt;
	logic [SURV_LEN-1:0] emit_word;

	logic in_acc;
	logic pop;
	logic free;
	logic process;

	// branch metrics for the five ideal levels
	always_comb begin
		for (int l = 0; l < NUM_LEVELS; l++) begin
			diff[l] = DIFF_W'(sample_s1) - DIFF_W'((l - 2) * (2 ** FRAC_BITS));
			mag[l]  = diff[l][DIFF_W-1] ? DIFF_W'(-diff[l]) : DIFF_W'(diff[l]);
			bm[l]   = SQ_W'(mag[l]) * SQ_W'(mag[l]);
		end
	end

	// add-compare-select, predecessors s>>1 and (s>>1)+2, ties go to the higher one
	always_comb begin
		for (int s = 0; s < NUM_STATES; s++) begin
			sum_a[s] = SUM_W'(metric_q[s >> 1]) + SUM_W'(bm[(s & 1) + 2 * (s >> 1)]);
			sum_b[s] = SUM_W'(metric_q[(s >> 1) + 2]) + SUM_W'(bm[(s & 1) + 2 * (s >> 1) + 1]);
			ca[s] = (sum_a[s] > METRIC_MAX) ? {METRIC_WIDTH{1'b1}} : sum_a[s][METRIC_WIDTH-1:0];
			cb[s] = (sum_b[s] > METRIC_MAX) ? {METRIC_WIDTH{1'b1}} : sum_b[s][METRIC_WIDTH-1:0];
			if (ca[s] < cb[s]) begin
				nm[s] = ca[s];
				ns[s] = {surv_q[s >> 1][DEPTH-1:0], 1'(s & 1)};
			end else begin
				nm[s] = cb[s];
				ns[s] = {surv_q[(s >> 1) + 2][DEPTH-1:0], 1'(s & 1)};
			end
		end
	end

	// best state, lowest number on a tie, then normalise
	always_comb begin
		best = 2'd0;
		lo   = nm[0];
		for (int s = 1; s < NUM_STATES; s++) begin
			if (nm[s] < lo) begin
				lo   = nm[s];
				best = 2'(s);
			end
		end
		for (int s = 0; s < NUM_STATES; s++) begin
			norm[s] = nm[s] - lo;
		end
	end

	always_comb begin
		if (fill_q < FILL_W'(DEPTH)) begin
			nvalid   = CNT_W'(fill_q) + CNT_W'(1);
			fill_nxt = fill_q + FILL_W'(1);
		end else begin
			nvalid   = CNT_W'(SURV_LEN);
			fill_nxt = fill_q;
		end
		if (eob_s1) begin
			emit_cnt  = nvalid;
			emit_word = ns[best] << (CNT_W'(SURV_LEN) - nvalid);
		end else begin
			emit_cnt  = (nvalid == CNT_W'(SURV_LEN)) ? CNT_W'(1) : CNT_W'(0);
			emit_word = ns[best];
		end
	end

	assign pop     = bit_ch.valid && bit_ch.ready;
	assign free    = (cnt_q == CNT_W'(0)) || ((cnt_q == CNT_W'(1)) && bit_ch.ready);
	assign process = valid_s1 && free;
	assign in_acc  = samp_ch.valid && samp_ch.ready;

	assign samp_ch.ready      = !valid_s1 || free;
	assign bit_ch.valid       = (cnt_q != CNT_W'(0));
	assign bit_ch.bit_res     = bits_q[DEPTH];
	assign bit_ch.last_of_run = flush_q && (cnt_q == CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (process) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_s1 <= samp_ch.sample;
			eob_s1    <= samp_ch.end_of_block;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_STATES; s++) begin
				metric_q[s] <= '0;
				surv_q[s]   <= '0;
			end
			fill_q <= '0;
		end else if (process) begin
			for (int s = 0; s < NUM_STATES; s++) begin
				metric_q[s] <= eob_s1 ? '0 : norm[s];
				surv_q[s]   <= eob_s1 ? '0 : ns[s];
			end
			fill_q <= eob_s1 ? '0 : fill_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q  <= '0;
			cnt_q   <= '0;
			flush_q <= 1'b0;
		end else if (process) begin
			bits_q  <= emit_word;
			cnt_q   <= emit_cnt;
			flush_q <= eob_s1;
		end else if (pop) begin
			bits_q <= {bits_q[DEPTH-1:0], 1'b0};
			cnt_q  <= cnt_q - CNT_W'(1);
		end
	end

endmodule

FILE: rtl/vd_checker.sv
module vd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic bit_res,
	input logic last_of_run
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("bit_ch valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(bit_res) && $stable(last_of_run))
		else $error("bit_ch payload changed while stalled");

	// only one sample may sit behind a stalled result
	a_in_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready && in_valid && in_ready) ##1 (out_valid && !out_ready)
		|-> !in_ready)
		else $error("samp_ch accepted a second transaction behind a stalled result");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("bit_ch valid during reset");

endmodule

bind viterbi_detector_pr121_4state vd_checker u_vd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (samp_ch.valid),
	.in_ready    (samp_ch.ready),
	.out_valid   (bit_ch.valid),
	.out_ready   (bit_ch.ready),
	.bit_res     (bit_ch.bit_res),
	.last_of_run (bit_ch.last_of_run)
);
